FILE: rtl/core/dbgf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbgf_pkg
// Types, constants and the control store of the dual-gauge fusion sequencer.
// ----------------------------------------------------------------------------
package dbgf_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MAIN_WEIGHT   = 2'd0,
    REG_SECOND_WEIGHT = 2'd1,
    REG_DISP_DIVISOR  = 2'd2,
    REG_CHG_FLOOR     = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] MainWeightRst   = 16'd2900;
  localparam logic [15:0] SecondWeightRst = 16'd1250;
  localparam logic [7:0]  DispDivisorRst  = 8'd97;
  localparam logic [15:0] ChgFloorRst     = 16'hFFEC;   // -20 mA

  // Quotient width of both long divisions (fine soc and display soc are below 2^14)
  localparam int unsigned DivBits = 14;

  // Voltage: (8*a + 2*b)/10 == (4*a + b)/5, and x/5 == (x * VoltRecip) >> VoltShift
  // for every x below 2^19
  localparam logic [18:0] VoltRecip = 19'd419431;
  localparam int unsigned VoltShift = 21;

  localparam logic [6:0]  SocMax  = 7'd100;
  localparam logic [18:0] Scale100 = 19'd100;

  localparam int unsigned PcW = 4;

  // Program step addresses
  localparam logic [PcW-1:0] StepWait     = 4'd0;
  localparam logic [PcW-1:0] StepFineLoop = 4'd8;
  localparam logic [PcW-1:0] StepDispLoop = 4'd11;
  localparam logic [PcW-1:0] StepEmit     = 4'd13;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MS_NONE = 3'd0,
    MS_VOLT = 3'd1,
    MS_SA   = 3'd2,
    MS_SB   = 3'd3,
    MS_X100 = 3'd4
  } mul_sel_t;

  // Accumulator operation
  typedef enum logic [1:0] {
    AC_NONE = 2'd0,
    AC_LOAD = 2'd1,
    AC_ADD  = 2'd2,
    AC_VOLT = 2'd3
  } acc_op_t;

  // Divider operation
  typedef enum logic [1:0] {
    DV_NONE       = 2'd0,
    DV_START_FINE = 2'd1,
    DV_START_DISP = 2'd2,
    DV_STEP       = 2'd3
  } div_op_t;

  // Post-processing operation
  typedef enum logic [1:0] {
    PO_NONE = 2'd0,
    PO_FINE = 2'd1,
    PO_DISP = 2'd2,
    PO_EMIT = 2'd3
  } post_op_t;

  // Jump condition
  typedef enum logic [1:0] {
    JC_NEXT        = 2'd0,
    JC_WAIT_IN     = 2'd1,
    JC_DIV_LOOP    = 2'd2,
    JC_OUT_BLOCKED = 2'd3
  } jcond_t;

  typedef struct packed {
    mul_sel_t       mul_sel;
    acc_op_t        acc_op;
    div_op_t        div_op;
    post_op_t       post_op;
    jcond_t         jcond;
    logic [PcW-1:0] jtarget;
    logic           ends;
  } ctrl_word_t;

  // Control store: one word per program step
  function automatic ctrl_word_t ctrl_rom(input logic [PcW-1:0] pc);
    ctrl_word_t w;
    w = '{MS_NONE, AC_NONE, DV_NONE, PO_NONE, JC_NEXT, StepWait, 1'b0};
    unique case (pc)
      4'd0:  w.jcond = JC_WAIT_IN;
      4'd1:  w.mul_sel = MS_VOLT;
      4'd2:  begin
        w.mul_sel = MS_SA;
        w.acc_op  = AC_VOLT;
      end
      4'd3:  begin
        w.mul_sel = MS_SB;
        w.acc_op  = AC_LOAD;
      end
      4'd4:  w.acc_op  = AC_ADD;
      4'd5:  w.mul_sel = MS_X100;
      4'd6:  w.acc_op  = AC_LOAD;
      4'd7:  w.div_op  = DV_START_FINE;
      4'd8:  begin
        w.div_op  = DV_STEP;
        w.jcond   = JC_DIV_LOOP;
        w.jtarget = StepFineLoop;
      end
      4'd9:  w.post_op = PO_FINE;
      4'd10: w.div_op  = DV_START_DISP;
      4'd11: begin
        w.div_op  = DV_STEP;
        w.jcond   = JC_DIV_LOOP;
        w.jtarget = StepDispLoop;
      end
      4'd12: w.post_op = PO_DISP;
      4'd13: begin
        w.post_op = PO_EMIT;
        w.jcond   = JC_OUT_BLOCKED;
        w.jtarget = StepEmit;
        w.ends    = 1'b1;
      end
      default: w.ends = 1'b1;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/dual_battery_gauge_fusion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_battery_gauge_fusion
// Fuses one sample of two parallel battery gauges into one pack reading.
// ----------------------------------------------------------------------------
// One sample is taken at a time and gives one result. Between its transfer and
// the result appearing, a 14-step control program runs a shared multiplier
// three times for the capacity-weighted soc, once for the voltage (reciprocal
// multiply), and a shared one-bit-per-cycle divider twice for 14 quotient bits
// each (fine soc, then display percent). The next sample is taken as soon as
// the result is loaded into the output register, even if that result has not
// yet been taken; the program waits at its last step only while an older
// result still blocks the output register. Configuration registers are written
// through cfg_we/cfg_addr/cfg_wdata; the user must write them only while the
// block is idle (the block does not enforce it); display_divisor takes the low 8 data bits.

module dual_battery_gauge_fusion (
  input  logic         clk,
  input  logic         rst_n,
  // cfg
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata,
  // sample in
  input  logic         in_tvalid,
  output logic         in_tready,
  // main_voltage[15:0], second_voltage[31:16], main_current[47:32],
  // second_current[63:48], main_temp[79:64], second_temp[95:80],
  // main_soc[102:96], second_soc[109:103], charger_present[110], zero pad[111]
  input  logic [111:0] in_tdata,
  // result out
  output logic         out_tvalid,
  input  logic         out_tready,
  // fused_voltage[15:0], fused_current[32:16], fused_temp[48:33], display_soc[55:49]
  output logic [55:0]  out_tdata
);

  // Configuration registers
  logic [15:0] main_weight_r;
  logic [15:0] second_weight_r;
  logic [7:0]  disp_div_r;
  logic [15:0] chg_floor_r;

  // Sequencer
  logic [dbgf_pkg::PcW-1:0] pc_r, pc_nxt;
  dbgf_pkg::ctrl_word_t     cw;
  logic                     cond_true, hold, op_en;

  // Sample registers
  logic [15:0] main_v_r, second_v_r;
  logic signed [15:0] main_i_r, second_i_r, main_t_r, second_t_r;
  logic [6:0]  main_soc_r, second_soc_r;
  logic        chg_r;

  // Datapath
  logic [23:0] mul_a;
  logic [18:0] mul_b;
  logic [42:0] prod_r;
  logic [30:0] acc_r;
  logic [15:0] volt_r;
  logic [13:0] fine_r;
  logic [6:0]  disp_r;
  logic [6:0]  last_r, last_nxt;

  // Divider
  logic [16:0] rem_r, den_r;
  logic [13:0] num_lo_r, quo_r;
  logic [3:0]  cnt_r;
  logic [17:0] trial, trial_diff;
  logic        trial_ge;

  // Output register
  logic        out_valid_r;
  logic [55:0] out_data_r;
  logic        in_xfer, out_blocked;

  logic [16:0] wsum;
  logic signed [16:0] curr_sum, temp_sum, temp_adj, floor_ext;
  logic [15:0] temp_half;
  logic [14:0] disp_raw;
  logic        rnd_up;
  logic [6:0]  disp_map, disp_fin;

  assign in_xfer     = in_tvalid && in_tready;
  assign out_blocked = out_valid_r && !out_tready;
  assign in_tready   = (pc_r == dbgf_pkg::StepWait);
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;

  assign wsum = {1'b0, main_weight_r} + {1'b0, second_weight_r};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_weight_r   <= dbgf_pkg::MainWeightRst;
      second_weight_r <= dbgf_pkg::SecondWeightRst;
      disp_div_r      <= dbgf_pkg::DispDivisorRst;
      chg_floor_r     <= dbgf_pkg::ChgFloorRst;
    end else if (cfg_we) begin
      unique case (dbgf_pkg::cfg_reg_t'(cfg_addr))
        dbgf_pkg::REG_MAIN_WEIGHT:   main_weight_r   <= cfg_wdata;
        dbgf_pkg::REG_SECOND_WEIGHT: second_weight_r <= cfg_wdata;
        dbgf_pkg::REG_DISP_DIVISOR:  disp_div_r      <= cfg_wdata[7:0];
        dbgf_pkg::REG_CHG_FLOOR:     chg_floor_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decode the current step and pick the next one
  always_comb begin
    cw = dbgf_pkg::ctrl_rom(pc_r);
    case (cw.jcond)
      dbgf_pkg::JC_WAIT_IN:     cond_true = !in_xfer;
      dbgf_pkg::JC_DIV_LOOP:    cond_true = (cnt_r != 4'd1);
      dbgf_pkg::JC_OUT_BLOCKED: cond_true = out_blocked;
      default:                  cond_true = 1'b0;
    endcase
    hold  = cond_true && (cw.jcond == dbgf_pkg::JC_WAIT_IN ||
                          cw.jcond == dbgf_pkg::JC_OUT_BLOCKED);
    op_en = !hold;
    if (cond_true) begin
      pc_nxt = cw.jtarget;
    end else if (cw.ends) begin
      pc_nxt = dbgf_pkg::StepWait;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= dbgf_pkg::StepWait;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Capture the sample on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      main_v_r     <= in_tdata[15:0];
      second_v_r   <= in_tdata[31:16];
      main_i_r     <= in_tdata[47:32];
      second_i_r   <= in_tdata[63:48];
      main_t_r     <= in_tdata[79:64];
      second_t_r   <= in_tdata[95:80];
      main_soc_r   <= in_tdata[102:96];
      second_soc_r <= in_tdata[109:103];
      chg_r        <= in_tdata[110];
    end
  end

  // Select multiplier operands
  always_comb begin
    case (cw.mul_sel)
      dbgf_pkg::MS_VOLT: begin
        mul_a = {6'd0, main_v_r, 2'b00} + {8'd0, second_v_r};
        mul_b = dbgf_pkg::VoltRecip;
      end
      dbgf_pkg::MS_SA: begin
        mul_a = {17'd0, main_soc_r};
        mul_b = {3'd0, main_weight_r};
      end
      dbgf_pkg::MS_SB: begin
        mul_a = {17'd0, second_soc_r};
        mul_b = {3'd0, second_weight_r};
      end
      dbgf_pkg::MS_X100: begin
        mul_a = acc_r[23:0];
        mul_b = dbgf_pkg::Scale100;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // One restoring division step
  assign trial      = {rem_r, num_lo_r[13]};
  assign trial_ge   = trial >= {1'b0, den_r};
  assign trial_diff = trial - {1'b0, den_r};

  // Display mapping: round half up, clamp, saturate on a zero divisor
  assign rnd_up   = {rem_r[7:0], 1'b0} >= {1'b0, disp_div_r};
  assign disp_raw = {1'b0, quo_r} + {14'd0, rnd_up};
  assign disp_map = (disp_div_r == 8'd0 || disp_raw > {8'd0, dbgf_pkg::SocMax})
                    ? dbgf_pkg::SocMax : disp_raw[6:0];

  // Current, temperature and the hold rules
  assign curr_sum  = 17'(main_i_r) + 17'(second_i_r);
  assign temp_sum  = 17'(main_t_r) + 17'(second_t_r);
  assign temp_adj  = temp_sum + {16'd0, temp_sum[16]};
  assign temp_half = temp_adj[16:1];
  assign floor_ext = 17'($signed(chg_floor_r));

  always_comb begin
    last_nxt = (last_r == 7'd0) ? disp_r : last_r;
    disp_fin = disp_r;
    if (chg_r) begin
      if (last_nxt > disp_r && curr_sum > floor_ext) begin
        disp_fin = last_nxt;
      end
    end else begin
      if (curr_sum < 17'sd0 && last_nxt < disp_r) begin
        disp_fin = last_nxt;
      end
    end
  end

  // Datapath registers, driven by the control word
  always_ff @(posedge clk) begin
    if (op_en) begin
      if (cw.mul_sel != dbgf_pkg::MS_NONE) begin
        prod_r <= {19'd0, mul_a} * {24'd0, mul_b};
      end
      case (cw.acc_op)
        dbgf_pkg::AC_LOAD: acc_r  <= prod_r[30:0];
        dbgf_pkg::AC_ADD:  acc_r  <= acc_r + prod_r[30:0];
        dbgf_pkg::AC_VOLT: volt_r <= prod_r[dbgf_pkg::VoltShift +: 16];
        default: ;
      endcase
      case (cw.div_op)
        dbgf_pkg::DV_START_FINE: begin
          rem_r    <= acc_r[30:14];
          num_lo_r <= acc_r[13:0];
          den_r    <= wsum;
          cnt_r    <= 4'(dbgf_pkg::DivBits);
        end
        dbgf_pkg::DV_START_DISP: begin
          rem_r    <= '0;
          num_lo_r <= fine_r;
          den_r    <= {9'd0, disp_div_r};
          cnt_r    <= 4'(dbgf_pkg::DivBits);
        end
        dbgf_pkg::DV_STEP: begin
          rem_r    <= trial_ge ? trial_diff[16:0] : trial[16:0];
          quo_r    <= {quo_r[12:0], trial_ge};
          num_lo_r <= {num_lo_r[12:0], 1'b0};
          cnt_r    <= cnt_r - 4'd1;
        end
        default: ;
      endcase
      case (cw.post_op)
        dbgf_pkg::PO_FINE: fine_r <= (wsum == 17'd0) ? 14'd0 : quo_r;
        dbgf_pkg::PO_DISP: disp_r <= disp_map;
        dbgf_pkg::PO_EMIT: out_data_r <= {disp_fin, temp_half, curr_sum, volt_r};
        default: ;
      endcase
    end
  end

  // Remembered display value and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (op_en && cw.post_op == dbgf_pkg::PO_EMIT) begin
        last_r      <= disp_fin;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/dbgf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbgf_checker
// Port-level checks of the gauge fusion block, bound to the top level.
// ----------------------------------------------------------------------------
module dbgf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // One sample at a time: ready drops after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a sample is in work");

  // A new result shows up just as the block goes back to waiting
  a_result_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result appeared while a sample is in work");

  // Displayed soc never exceeds 100
  a_soc_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:49] <= 7'd100)
    else $error("display soc above 100");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind dual_battery_gauge_fusion dbgf_checker u_dbgf_checker (.*);
